FILE: rtl/slfp_pkg.sv
// ----------------------------------------------------------------------------
// Signal lamp frame to pin driver package
// Beat types, frame identifier codes, colour masks and the pin mapping
// shared by the lamp state keeper, the pin mapper and the top level.
// ----------------------------------------------------------------------------
package slfp_pkg;

    // frame identifiers and length codes
    localparam logic [10:0] ID_LAMP_FIRST = 11'h301;
    localparam logic [10:0] ID_LAMP_LAST  = 11'h304;
    localparam logic [10:0] ID_KEY        = 11'h110;
    localparam logic [3:0]  LEN_LAMP      = 4'd5;
    localparam logic [3:0]  LEN_KEY       = 4'd1;
    localparam logic [7:0]  MODE_MIRROR   = 8'd2;

    // colour mask bit positions
    localparam int COL_GREEN  = 0;
    localparam int COL_RED    = 1;
    localparam int COL_YELLOW = 2;

    // geometry and pin word layout
    localparam int GROUPS   = 4;
    localparam int LAMPS    = 4;
    localparam int PED_LAMP = 3;
    localparam int PED_BASE = 12;

    localparam logic [4:0] KEY_RESET = 5'h1F;

    typedef logic [2:0]        t_colour;
    typedef t_colour [3:0]     t_group;
    typedef t_group  [3:0]     t_lamp_map;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_length;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] green_pins;
        logic [15:0] red_pins;
        logic [11:0] yellow_pins;
        logic        lamp_update;
        logic [4:0]  key_pins;
        logic        key_update;
        logic        activity_off;
    } t_out_beat;

    // per-frame decode flags handed from the state keeper to the top level
    typedef struct packed {
        logic lamp_up;
        logic key_up;
        logic act;
    } t_frame_ctl;

    // pin bit of vehicle lamp l in group g
    function automatic logic [3:0] vehicle_bit(input logic [1:0] g, input logic [1:0] l);
        logic [3:0] b;
        unique case (g)
            2'd0: b = 4'd6 + {2'b00, l};
            2'd1: b = 4'd3 + {2'b00, l};
            2'd2: b = {2'b00, l};
            default: b = 4'd9 + {2'b00, l};
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/signal_lamp_frame_to_pin_driver_top.sv
// ----------------------------------------------------------------------------
// Signal lamp frame to pin driver, top level
// Input register, lamp state update with pin mapping, result register.
// ----------------------------------------------------------------------------
// One frame beat is taken every clock cycle while the input is not stalled, and
// each gives one result beat: the frame waits in the input register, then the
// state update and pin mapping write the result register. The only loop is the
// lamp state keeper, which is read and written in the same cycle, so frames follow back to back.
// Lamp pins read off and key lamps off after reset; activity_off is high on
// every fourth frame. Input stall rises only while both registers are full and
// the result register is held by the output stall.
module signal_lamp_frame_to_pin_driver_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  slfp_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output slfp_pkg::t_out_beat  o_out_beat
);
    import slfp_pkg::*;

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out, n_out;
    logic       advance;
    t_lamp_map  colours_nxt;
    logic [4:0] keys_nxt;
    t_frame_ctl ctl;
    logic [15:0] green, red;
    logic [11:0] yellow;

    // pipeline moves when the result register is free or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    slfp_lamp_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance && r_in_valid),
        .i_beat        (r_in),
        .o_colours_nxt (colours_nxt),
        .o_keys_nxt    (keys_nxt),
        .o_ctl         (ctl)
    );

    slfp_pin_map u_map (
        .i_colours (colours_nxt),
        .o_green   (green),
        .o_red     (red),
        .o_yellow  (yellow)
    );

    // result beat assembly
    always_comb begin
        n_out.green_pins   = green;
        n_out.red_pins     = red;
        n_out.yellow_pins  = yellow;
        n_out.lamp_update  = ctl.lamp_up;
        n_out.key_pins     = keys_nxt;
        n_out.key_update   = ctl.key_up;
        n_out.activity_off = ctl.act;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // checks
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled result beat changed");

endmodule

FILE: rtl/slfp_lamp_state.sv
// ----------------------------------------------------------------------------
// Lamp state keeper
// Decodes one frame, holds the lamp colour masks, the key lamp pins and the
// activity divider, and presents the state as it stands after the frame.
// ----------------------------------------------------------------------------
module slfp_lamp_state (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  slfp_pkg::t_in_beat     i_beat,
    output slfp_pkg::t_lamp_map    o_colours_nxt,
    output logic [4:0]             o_keys_nxt,
    output slfp_pkg::t_frame_ctl   o_ctl
);
    import slfp_pkg::*;

    t_lamp_map  r_colours, n_colours;
    logic [4:0] r_keys, n_keys;
    logic [1:0] r_count;
    logic       is_key, is_lamp;
    logic [1:0] grp;
    logic [10:0] id_off;

    // frame classification
    assign is_key  = (i_beat.frame_length == LEN_KEY) && (i_beat.frame_id == ID_KEY);
    assign is_lamp = (i_beat.frame_length == LEN_LAMP) && (i_beat.frame_id >= ID_LAMP_FIRST)
                     && (i_beat.frame_id <= ID_LAMP_LAST);
    assign id_off  = i_beat.frame_id - ID_LAMP_FIRST;
    assign grp     = id_off[1:0];

    // next lamp and key state
    always_comb begin
        n_colours = r_colours;
        n_keys    = r_keys;
        if (is_key) begin
            n_keys = ~i_beat.byte0[4:0];
        end else if (is_lamp) begin
            n_colours[grp] = {i_beat.byte4[2:0], i_beat.byte3[2:0],
                              i_beat.byte2[2:0], i_beat.byte1[2:0]};
            if (i_beat.byte0 == MODE_MIRROR) begin
                n_colours[2] = n_colours[0];
                n_colours[3] = n_colours[1];
            end
        end
    end

    assign o_colours_nxt = n_colours;
    assign o_keys_nxt    = n_keys;
    assign o_ctl.key_up  = is_key;
    assign o_ctl.lamp_up = is_lamp && !is_key;
    assign o_ctl.act     = (r_count == 2'd3);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colours <= '0;
            r_keys    <= KEY_RESET;
            r_count   <= 2'd0;
        end else if (i_en) begin
            r_colours <= n_colours;
            r_keys    <= n_keys;
            r_count   <= r_count + 2'd1;
        end
    end

    // checks
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_count))
        else $error("activity divider moved without a frame");
    a_lamp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !o_ctl.lamp_up) |=> $stable(r_colours))
        else $error("lamp colours changed on a non-lamp frame");
    a_key_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !o_ctl.key_up) |=> $stable(r_keys))
        else $error("key lamps changed on a non-key frame");
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |-> !(o_ctl.key_up && o_ctl.lamp_up))
        else $error("frame decoded as both key and lamp frame");

endmodule

FILE: rtl/slfp_pin_map.sv
// ----------------------------------------------------------------------------
// Pin mapper
// Turns the sixteen colour masks into the active-low green, red and yellow
// pin words through the fixed board mapping.
// ----------------------------------------------------------------------------
module slfp_pin_map (
    input  slfp_pkg::t_lamp_map i_colours,
    output logic [15:0]         o_green,
    output logic [15:0]         o_red,
    output logic [11:0]         o_yellow
);
    import slfp_pkg::*;

    // vehicle lamps to their bits, pedestrian lamps to the top nibble
    always_comb begin
        o_green  = '0;
        o_red    = '0;
        o_yellow = '0;
        for (int g = 0; g < GROUPS; g++) begin
            for (int l = 0; l < PED_LAMP; l++) begin
                o_green[vehicle_bit(2'(g), 2'(l))]  = ~i_colours[g][l][COL_GREEN];
                o_red[vehicle_bit(2'(g), 2'(l))]    = ~i_colours[g][l][COL_RED];
                o_yellow[vehicle_bit(2'(g), 2'(l))] = ~i_colours[g][l][COL_YELLOW];
            end
            o_green[PED_BASE + g] = ~i_colours[g][PED_LAMP][COL_GREEN];
            o_red[PED_BASE + g]   = ~i_colours[g][PED_LAMP][COL_RED];
        end
    end

endmodule

FILE: dv/slfp_frame_checker.sv
// ----------------------------------------------------------------------------
// Signal lamp frame checker
// Watches the frame and result channels of the lamp pin driver, predicts the
// pin words for every accepted frame and compares each result beat in order.
// ----------------------------------------------------------------------------
module slfp_frame_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  slfp_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  slfp_pkg::t_out_beat i_out_beat,
    output int                  o_fail_count,
    output int                  o_pending
);
    import slfp_pkg::*;

    // predicted lamp, key and activity state
    t_lamp_map  lamp_store;
    logic [1:0] frame_phase;
    logic [4:0] key_lamp_pins;

    t_out_beat  pin_results_due[$];
    t_out_beat  oldest_due;
    int         mismatch_total = 0;
    int         results_waiting = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = results_waiting;

    // active-low pin word of one colour: set bit when the lamp lacks it
    function automatic logic [15:0] lamp_pins_off(input int colour);
        logic [15:0] word;
        int          pin_base;
        word = '0;
        for (int g = 0; g < GROUPS; g++) begin
            case (g)
                0: begin
                    pin_base = 6;
                end
                1: begin
                    pin_base = 3;
                end
                2: begin
                    pin_base = 0;
                end
                default: begin
                    pin_base = 9;
                end
            endcase
            for (int l = 0; l < LAMPS; l++) begin
                if (!lamp_store[g][l][colour]) begin
                    // pedestrian lamps carry green and red only
                    if (l == PED_LAMP) begin
                        if (colour != COL_YELLOW) word[PED_BASE + g] = 1'b1;
                    end else begin
                        word[pin_base + l] = 1'b1;
                    end
                end
            end
        end
        return word;
    endfunction

    // apply one frame to the predicted state and build its result beat
    function automatic t_out_beat predict_pin_result(input t_in_beat f);
        t_out_beat   res;
        logic [1:0]  grp;
        logic [10:0] grp_offset;
        logic [15:0] yellow_word;
        res = '0;
        if (f.frame_id == ID_KEY && f.frame_length == LEN_KEY) begin
            key_lamp_pins  = ~f.byte0[4:0];
            res.key_update = 1'b1;
        end else if (f.frame_length == LEN_LAMP && f.frame_id >= ID_LAMP_FIRST
                     && f.frame_id <= ID_LAMP_LAST) begin
            grp_offset      = f.frame_id - ID_LAMP_FIRST;
            grp             = grp_offset[1:0];
            lamp_store[grp] = {f.byte4[2:0], f.byte3[2:0], f.byte2[2:0], f.byte1[2:0]};
            // mirror mode copies groups 0 and 1 onto 2 and 3
            if (f.byte0 == MODE_MIRROR) begin
                lamp_store[2] = lamp_store[0];
                lamp_store[3] = lamp_store[1];
            end
            res.lamp_update = 1'b1;
        end
        res.activity_off = (frame_phase == 2'd3);
        frame_phase      = frame_phase + 2'd1;
        yellow_word      = lamp_pins_off(COL_YELLOW);
        res.green_pins   = lamp_pins_off(COL_GREEN);
        res.red_pins     = lamp_pins_off(COL_RED);
        res.yellow_pins  = yellow_word[11:0];
        res.key_pins     = key_lamp_pins;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    // predict on accepted frames, compare on accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lamp_store    = '0;
            frame_phase   = '0;
            key_lamp_pins = KEY_RESET;
            pin_results_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                pin_results_due.push_back(predict_pin_result(i_in_beat));
            if (i_out_valid && !i_out_stall) begin
                if (pin_results_due.size() == 0) begin
                    $display("%0t: result beat with no frame waiting, expected none actual %p",
                             $time, i_out_beat);
                    mismatch_total++;
                end else begin
                    oldest_due = pin_results_due.pop_front();
                    check_field("green_pins", oldest_due.green_pins, i_out_beat.green_pins);
                    check_field("red_pins", oldest_due.red_pins, i_out_beat.red_pins);
                    check_field("yellow_pins", {4'h0, oldest_due.yellow_pins},
                                {4'h0, i_out_beat.yellow_pins});
                    check_field("lamp_update", {15'h0, oldest_due.lamp_update},
                                {15'h0, i_out_beat.lamp_update});
                    check_field("key_pins", {11'h0, oldest_due.key_pins},
                                {11'h0, i_out_beat.key_pins});
                    check_field("key_update", {15'h0, oldest_due.key_update},
                                {15'h0, i_out_beat.key_update});
                    check_field("activity_off", {15'h0, oldest_due.activity_off},
                                {15'h0, i_out_beat.activity_off});
                end
            end
        end
        results_waiting = pin_results_due.size();
    end

endmodule

FILE: dv/signal_lamp_frame_to_pin_driver_top_tb.sv
// ----------------------------------------------------------------------------
// Signal lamp frame to pin driver testbench
// Drives directed and random bus frames through the pin driver under several
// sender gap and receiver stall mixes; the checker scores every result beat.
// ----------------------------------------------------------------------------
module signal_lamp_frame_to_pin_driver_top_tb;
    import slfp_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    always #2 clk = ~clk;

    signal_lamp_frame_to_pin_driver_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    slfp_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // offer one frame beat, with random gaps before it, and hold until taken
    task automatic send_frame(input logic [10:0] id, input logic [3:0] len,
                              input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic [7:0] b4);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{frame_id: id, frame_length: len, byte0: b0, byte1: b1,
                      byte2: b2, byte3: b3, byte4: b4};
        do @(posedge clk); while (!(in_valid && !in_stall));
        @(negedge clk);
    endtask

    // run ends here if the block hangs
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [31:0] rnd_a;
        logic [31:0] rnd_b;
        logic [10:0] id;
        logic [3:0]  len;
        logic [7:0]  mode;
        int unsigned kind;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset state shows on an ignored frame
        send_frame(11'h000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // each group, full and partial colour masks, high bits ignored
        send_frame(ID_LAMP_FIRST, LEN_LAMP, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h04);
        send_frame(ID_LAMP_FIRST + 11'd1, LEN_LAMP, 8'hFF, 8'h07, 8'hF8, 8'h03, 8'h05);
        send_frame(ID_LAMP_FIRST + 11'd2, LEN_LAMP, 8'h01, 8'h06, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_LAST, LEN_LAMP, 8'h03, 8'h07, 8'h00, 8'h07, 8'hFB);
        // mirror mode from group 0, from the last group and from group 1
        send_frame(ID_LAMP_FIRST, LEN_LAMP, MODE_MIRROR, 8'h01, 8'h02, 8'h04, 8'h03);
        send_frame(ID_LAMP_LAST, LEN_LAMP, MODE_MIRROR, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_FIRST + 11'd1, LEN_LAMP, MODE_MIRROR, 8'h00, 8'h00, 8'h00, 8'h00);
        // key lamps all on, all off, mixed
        send_frame(ID_KEY, LEN_KEY, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(ID_KEY, LEN_KEY, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(ID_KEY, LEN_KEY, 8'h15, 8'h00, 8'h00, 8'h00, 8'h00);
        // wrong lengths and neighboring identifiers are ignored
        send_frame(ID_KEY, LEN_LAMP, 8'h1F, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_KEY, 4'd0, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(ID_LAMP_FIRST, LEN_KEY, 8'h00, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_FIRST, 4'd4, 8'h00, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_FIRST, 4'd6, 8'h00, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_FIRST, 4'd15, MODE_MIRROR, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_FIRST - 11'd1, LEN_LAMP, 8'h00, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(ID_LAMP_LAST + 11'd1, LEN_LAMP, MODE_MIRROR, 8'h07, 8'h07, 8'h07, 8'h07);
        send_frame(11'h7FF, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(11'h7FF, 4'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        // random frames under each idling mix
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            for (int n = 0; n < 240; n++) begin
                rnd_a = $urandom;
                rnd_b = $urandom;
                kind  = $urandom_range(99);
                mode  = rnd_b[30:29] == 2'd0 ? MODE_MIRROR : rnd_a[7:0];
                if (kind < 40) begin
                    // well-formed lamp frame
                    id  = ID_LAMP_FIRST + {9'b0, rnd_b[1:0]};
                    len = LEN_LAMP;
                end else if (kind < 55) begin
                    // key frame
                    id   = ID_KEY;
                    len  = LEN_KEY;
                    mode = rnd_a[7:0];
                end else if (kind < 70) begin
                    // near miss on identifier or length
                    case (rnd_b[26:24])
                        3'd0: begin
                            id = ID_KEY;
                        end
                        3'd1: begin
                            id = ID_LAMP_FIRST - 11'd1;
                        end
                        3'd2: begin
                            id = ID_LAMP_LAST + 11'd1;
                        end
                        default: begin
                            id = ID_LAMP_FIRST + {9'b0, rnd_b[1:0]};
                        end
                    endcase
                    len = rnd_b[22:19];
                end else begin
                    // noise
                    id   = rnd_b[18:8];
                    len  = rnd_b[22:19];
                    mode = rnd_a[7:0];
                end
                send_frame(id, len, mode, rnd_a[15:8], rnd_a[23:16], rnd_a[31:24],
                           rnd_b[7:0] ^ {rnd_b[31], rnd_b[28:27], 5'b0});
            end
        end
        in_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
